@@ design/flux_interval_accumulator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the flux interval accumulator
// ----------------------------------------------------------------------------
`ifndef FLUX_INTERVAL_ACCUMULATOR_ASSERT_SVH
`define FLUX_INTERVAL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FIA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flux_interval_accumulator: implication failed");

// next-cycle implication, checked outside reset
`define FIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flux_interval_accumulator: next-cycle implication failed");

`endif

@@ design/fia_pkg.sv @@
// ----------------------------------------------------------------------------
// fia_pkg
// Shared types and constants of the flux interval accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fia_pkg;

  localparam int TIME_W     = 32;
  localparam int WORD_W     = 16;
  localparam int CAP_W      = 20;
  localparam int CNT_OUT_W  = 20;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 3;

  localparam logic [TIME_W-1:0]     MARKER_ADD   = 32'h0001_0000;
  localparam logic [CAP_W-1:0]      CAP_RESET    = 20'hF_FFFF;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 3'd0;

  localparam logic KIND_TRANSITION = 1'b0;
  localparam logic KIND_SUMMARY    = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ERROR    = 1'b1;

  // one queued job: a transition beat, a summary beat, or both
  typedef struct packed {
    logic                 trans;
    logic                 summ;
    logic                 status;
    logic [TIME_W-1:0]    tval;
    logic [CNT_OUT_W-1:0] count;
  } fia_entry_t;

endpackage

`default_nettype wire

@@ design/flux_interval_accumulator.sv @@
// ----------------------------------------------------------------------------
// flux_interval_accumulator
// Turns one revolution of 16-bit flux intervals into absolute transition
// times, with a closing summary per revolution.
// ----------------------------------------------------------------------------
//  channel   dir   handshake           payload
//  in_       in    tvalid/tready       tdata flux_word, tuser first_word,
//                                      tlast last_word
//  out_      out   tvalid/tready       tdata time/count/status, tuser kind,
//                                      tlast last
//  cfg_      in    APB psel/penable    transition_capacity at 0x0
//
//  One flux word per cycle while the queue is not full. A last word with a
//  transition makes two beats, so the back end drains at one beat per cycle
//  while out_tready is high, and a four-entry queue absorbs the difference.
//  Results pass through the queue and then the output register. Reset
//  (synchronous, rst_n low) clears time, count and error and sets capacity
//  to all ones. Each side stalls on its own until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module flux_interval_accumulator #(
  parameter int COUNT_BITS = 20
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [fia_pkg::WORD_W-1:0]       in_tdata,   // [15:0] flux_word
  input  wire  [0:0]                       in_tuser,   // [0] first_word
  input  wire                              in_tlast,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [31:0] time_value, [51:32] transition_count, [52] status, [55:53] zero
  output logic [fia_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [0:0]                       out_tuser,  // [0] kind
  output logic                             out_tlast,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [fia_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire  [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import fia_pkg::*;

  `include "flux_interval_accumulator_assert.svh"

  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  logic             cfg_write;
  logic             q_full, q_push, q_pop, q_head_valid;
  fia_entry_t       q_entry, q_head;
  logic             back_kind;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_write && (cfg_paddr == REG_CAPACITY)) begin
      capacity_nxt = cfg_pwdata[CAP_W-1:0];
    end
    cfg_prdata = (cfg_paddr == REG_CAPACITY) ? 32'(capacity_r) : 32'h0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  fia_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .flux_word  (in_tdata),
    .first_word (in_tuser[0]),
    .last_word  (in_tlast),
    .capacity   (capacity_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  fia_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  fia_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (back_kind),
    .out_tlast  (out_tlast)
  );

  assign out_tuser[0] = back_kind;

  // a transition beat is never an error and never closes the revolution
  `FIA_ASSERT_IMPL(a_trans_plain, out_tvalid && !out_tuser[0], !out_tlast && !out_tdata[52])
  // a transition always carries a nonzero running count
  `FIA_ASSERT_IMPL(a_trans_count, out_tvalid && !out_tuser[0], out_tdata[51:32] != 20'd0)
  // a push is never offered while the queue is full
  `FIA_ASSERT_IMPL(a_no_push_full, q_push, !q_full)

endmodule

`default_nettype wire

@@ design/fia_front.sv @@
// ----------------------------------------------------------------------------
// fia_front
// Accepts flux words, keeps running time, count and error flag, queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_front #(
  parameter int COUNT_BITS = 20
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [fia_pkg::WORD_W-1:0]        flux_word,
  input  wire                               first_word,
  input  wire                               last_word,
  input  wire  [fia_pkg::CAP_W-1:0]         capacity,
  input  wire                               q_full,
  output logic                              q_push,
  output fia_pkg::fia_entry_t               q_entry
);
  import fia_pkg::*;

  localparam int LW = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

  logic [TIME_W-1:0]     time_r, time_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  failed_r, failed_nxt;

  logic [TIME_W-1:0]     time_cur;
  logic [COUNT_BITS-1:0] count_cur;
  logic                  failed_cur;
  logic [TIME_W-1:0]     add_v;
  logic [TIME_W:0]       sum_v;
  logic [LW-1:0]         cap_ext, cmax_ext, limit, cnt_ext;
  logic                  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign cap_ext  = LW'(capacity);
  assign cmax_ext = LW'({COUNT_BITS{1'b1}});
  assign limit    = (cap_ext > cmax_ext) ? cmax_ext : cap_ext;

  always_comb begin
    // a first mark clears state before the word is used
    time_cur   = first_word ? '0 : time_r;
    count_cur  = first_word ? '0 : count_r;
    failed_cur = first_word ? 1'b0 : failed_r;
    add_v      = (flux_word != '0) ? TIME_W'(flux_word) : MARKER_ADD;
    sum_v      = {1'b0, time_cur} + {1'b0, add_v};
    cnt_ext    = LW'(count_cur);

    time_nxt   = time_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    q_push     = 1'b0;
    q_entry    = '0;

    if (accept) begin
      time_nxt   = time_cur;
      count_nxt  = count_cur;
      failed_nxt = failed_cur;
      if (!failed_cur) begin
        if (sum_v[TIME_W]) begin
          failed_nxt     = 1'b1;
          q_push         = 1'b1;
          q_entry.summ   = 1'b1;
          q_entry.status = STATUS_ERROR;
          q_entry.tval   = time_cur;
          q_entry.count  = CNT_OUT_W'(count_cur);
        end else begin
          time_nxt     = sum_v[TIME_W-1:0];
          q_entry.tval = sum_v[TIME_W-1:0];
          if (flux_word != '0) begin
            if (cnt_ext >= limit) begin
              failed_nxt     = 1'b1;
              q_push         = 1'b1;
              q_entry.summ   = 1'b1;
              q_entry.status = STATUS_ERROR;
              q_entry.count  = CNT_OUT_W'(count_cur);
            end else begin
              count_nxt      = count_cur + 1'b1;
              q_push         = 1'b1;
              q_entry.trans  = 1'b1;
              q_entry.summ   = last_word;
              q_entry.status = STATUS_OK;
              q_entry.count  = CNT_OUT_W'(count_nxt);
            end
          end else begin
            q_push         = last_word;
            q_entry.summ   = last_word;
            q_entry.status = STATUS_OK;
            q_entry.count  = CNT_OUT_W'(count_cur);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r   <= '0;
      count_r  <= '0;
      failed_r <= 1'b0;
    end else begin
      time_r   <= time_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/fia_queue.sv @@
// ----------------------------------------------------------------------------
// fia_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  fia_pkg::fia_entry_t  push_entry,
  input  wire                  pop,
  output logic                 full,
  output logic                 head_valid,
  output fia_pkg::fia_entry_t  head_entry
);
  import fia_pkg::*;

  fia_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full       = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (fill_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/fia_back.sv @@
// ----------------------------------------------------------------------------
// fia_back
// Expands queued jobs into result beats through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              head_valid,
  input  fia_pkg::fia_entry_t              head_entry,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [fia_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);
  import fia_pkg::*;

  logic                  valid_r, valid_nxt;
  logic                  phase_r, phase_nxt;
  logic                  kind_r;
  logic                  status_r;
  logic [TIME_W-1:0]     tval_r;
  logic [CNT_OUT_W-1:0]  count_r;
  logic                  load;
  logic                  beat_is_sum;

  // second beat of a job is always its summary
  assign beat_is_sum = !head_entry.trans || phase_r;
  assign load        = head_valid && (!valid_r || out_tready);
  assign pop         = load && (beat_is_sum || !head_entry.summ);

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = !pop;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= beat_is_sum ? KIND_SUMMARY : KIND_TRANSITION;
      status_r <= beat_is_sum ? head_entry.status : STATUS_OK;
      tval_r   <= head_entry.tval;
      count_r  <= head_entry.count;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = (kind_r == KIND_SUMMARY);
  assign out_tdata  = {3'b000, status_r, count_r, tval_r};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: flux interval accumulator testbench
// Streams flux words into the block and checks every transition and summary
// beat against a cycle-free model of the running time, the transition count
// and the error latch. The capacity is changed between phases. A receiver
// hold-off and random idling on both sides are included.
// ----------------------------------------------------------------------------

module tb_top;
  import fia_pkg::*;

  localparam int CNT_W        = 20;
  localparam int MAX_IDLE     = 11;
  localparam int SETTLE       = 12;
  localparam int HOLD_CYCLES  = 150;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MAX_REPORTS  = 40;
  localparam int RANDOM_WORDS = 150;

  // idling styles for either side
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_FULL  = 1;
  localparam int IDLE_LIGHT = 2;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              first;
    logic              last;
  } flux_item_t;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] tval;
    logic [CNT_W-1:0]  count;
    logic              status;
    logic              last;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata = '0;   // [15:0] flux_word
  logic [0:0]            in_tuser = '0;   // [0] first_word
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [31:0] time_value, [51:32] transition_count, [52] status, [55:53] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;       // [0] kind
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  flux_interval_accumulator #(.COUNT_BITS(CNT_W)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  flux_item_t   flux_backlog[$];
  result_beat_t due_beats[$];

  // model state
  logic [TIME_W-1:0] acc_time = '0;
  logic [CNT_W-1:0]  acc_count = '0;
  logic              acc_failed = 1'b0;
  logic [CAP_W-1:0]  capacity = CAP_RESET;

  int  errors = 0;
  int  cycles = 0;
  int  queued_words = 0;
  int  in_mode = IDLE_FULL;
  int  out_mode = IDLE_FULL;
  int  in_wait = 0;
  int  out_wait = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;

  function automatic int draw_gap(input int mode);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_LIGHT && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  task automatic push_beat(input logic kind, input logic status, input logic last);
    result_beat_t b;
    b.kind   = kind;
    b.tval   = acc_time;
    b.count  = acc_count;
    b.status = status;
    b.last   = last;
    due_beats.push_back(b);
  endtask

  // one flux word through the accumulator: zero, one or two result beats
  task automatic predict_flux_word(input logic [WORD_W-1:0] word, input logic first,
                                   input logic last);
    logic [TIME_W-1:0] add;
    logic [TIME_W:0]   sum;
    if (first) begin
      acc_time   = '0;
      acc_count  = '0;
      acc_failed = 1'b0;
    end
    if (acc_failed) return;
    add = (word != '0) ? TIME_W'(word) : MARKER_ADD;
    sum = {1'b0, acc_time} + {1'b0, add};
    if (sum[TIME_W]) begin
      // overflow reports the time before the add
      acc_failed = 1'b1;
      push_beat(KIND_SUMMARY, STATUS_ERROR, 1'b1);
      return;
    end
    acc_time = sum[TIME_W-1:0];
    if (word != '0) begin
      if (acc_count >= capacity) begin
        acc_failed = 1'b1;
        push_beat(KIND_SUMMARY, STATUS_ERROR, 1'b1);
        return;
      end
      acc_count++;
      push_beat(KIND_TRANSITION, STATUS_OK, 1'b0);
    end
    if (last) push_beat(KIND_SUMMARY, STATUS_OK, 1'b1);
  endtask

  // sender
  always @(negedge clk) begin
    flux_item_t it;
    if (rst_n) begin
      if (in_tvalid && !in_fire) begin
        // beat still waiting for tready
      end else if (in_wait > 0) begin
        in_tvalid <= 1'b0;
        in_wait   <= in_wait - 1;
      end else if (flux_backlog.size() != 0) begin
        it = flux_backlog.pop_front();
        in_tdata  <= it.word;
        in_tuser  <= it.first;
        in_tlast  <= it.last;
        in_tvalid <= 1'b1;
        in_wait   <= draw_gap(in_mode);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    int g;
    if (rst_n) begin
      g = out_fire ? draw_gap(out_mode) : out_wait;
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        out_wait   <= g;
      end else if (g > 0) begin
        out_tready <= 1'b0;
        out_wait   <= g - 1;
      end else begin
        out_tready <= 1'b1;
        out_wait   <= 0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end
  end

  // input beats feed the model, output beats are checked
  always @(posedge clk) begin
    result_beat_t w;
    in_fire  <= in_tvalid && in_tready;
    out_fire <= out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready)
      predict_flux_word(in_tdata, in_tuser[0], in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (due_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], '0);
      end else begin
        w = due_beats.pop_front();
        if (out_tuser[0] != w.kind)
          report_mismatch("kind", 32'(out_tuser[0]), 32'(w.kind));
        if (out_tdata[31:0] != w.tval) report_mismatch("time", out_tdata[31:0], w.tval);
        if (out_tdata[51:32] != w.count)
          report_mismatch("count", 32'(out_tdata[51:32]), 32'(w.count));
        if (out_tdata[52] != w.status)
          report_mismatch("status", 32'(out_tdata[52]), 32'(w.status));
        if (out_tlast != w.last) report_mismatch("last", 32'(out_tlast), 32'(w.last));
        if (out_tdata[55:53] != '0) report_mismatch("pad", 32'(out_tdata[55:53]), '0);
      end
    end
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic queue_word(input logic [WORD_W-1:0] word, input logic first,
                            input logic last);
    flux_item_t it;
    it.word  = word;
    it.first = first;
    it.last  = last;
    flux_backlog.push_back(it);
    queued_words++;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r == 2) return '1;
    if (r == 3) return WORD_W'($urandom_range(1, 15));
    return WORD_W'($urandom_range(0, 65535));
  endfunction

  // mostly well-formed revolutions, some words with random marks
  task automatic push_revolution();
    int len;
    int k;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 11) == 0)
        queue_word(rand_word(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        queue_word(rand_word(), k == 0, k == len - 1);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (flux_backlog.size() != 0 || in_tvalid || due_beats.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // write the capacity register, then read it back
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_CAPACITY;
    cfg_pwdata  <= 32'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    capacity = value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata != 32'(value))
      report_mismatch("capacity readback", cfg_prdata, 32'(value));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    int p;
    logic [CAP_W-1:0] caps[8];
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset capacity; first word arrives with no first mark
    queue_word(16'd1, 1'b0, 1'b0);
    queue_word(16'hFFFF, 1'b1, 1'b0);
    queue_word(16'd0, 1'b0, 1'b0);
    queue_word(16'h8000, 1'b0, 1'b0);
    queue_word(16'd0, 1'b0, 1'b1);
    queue_word(16'd5, 1'b1, 1'b1);
    queue_word(16'd0, 1'b1, 1'b1);
    queue_word(16'h5555, 1'b1, 1'b0);
    queue_word(16'hAAAA, 1'b0, 1'b1);
    wait_idle();

    // capacity exceeded, then words dropped until the next first mark
    set_capacity(20'd2);
    queue_word(16'd3, 1'b1, 1'b0);
    queue_word(16'd4, 1'b0, 1'b0);
    queue_word(16'd5, 1'b0, 1'b0);
    queue_word(16'd6, 1'b0, 1'b1);
    queue_word(16'd0, 1'b0, 1'b0);
    queue_word(16'd0, 1'b1, 1'b1);
    wait_idle();

    // zero capacity: any transition fails, zero words still fine
    set_capacity(20'd0);
    queue_word(16'd7, 1'b1, 1'b1);
    queue_word(16'd0, 1'b1, 1'b1);
    wait_idle();

    // failing last word gives only the error summary
    set_capacity(20'd1);
    queue_word(16'd9, 1'b1, 1'b0);
    queue_word(16'd0, 1'b0, 1'b0);
    queue_word(16'd2, 1'b0, 1'b1);
    queue_word(16'd1, 1'b1, 1'b0);
    wait_idle();

    caps[0] = 20'd3;
    caps[1] = CAP_RESET;
    caps[2] = 20'd0;
    caps[3] = 20'd8;
    caps[4] = 20'd1;
    caps[5] = 20'd17;
    caps[6] = CAP_W'($urandom_range(1, 1048575));
    caps[7] = 20'd5;
    for (p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      in_mode  = p % 3;
      out_mode = (p + 1) % 3;
      if (p == 3) begin
        // sender keeps offering while the receiver is held off
        in_mode  = IDLE_NONE;
        out_mode = IDLE_FULL;
      end
      queued_words = 0;
      while (queued_words < RANDOM_WORDS) push_revolution();
      if (p == 3) hold_req++;
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
